FILE: src/acex_pkg.sv
// Shared types and constants for the accumulator machine execute block.
`timescale 1ns / 1ps
`default_nettype none

package acex_pkg;

   // Default sizes of the word memory and the data path
   localparam int DEF_MEM_WORDS = 2048;
   localparam int DEF_WORD_BITS = 16;

   // Fixed field widths
   localparam int FUNC_BITS = 4;
   localparam int PC_BITS   = 12;
   localparam int LOAD_BITS = 16;
   localparam int ACC_BITS  = 16;
   localparam int CYC_BITS  = 16;

   // Packed stream widths
   localparam int REQ_TDATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 48;

   // Highest word index that a byte address can reach
   localparam int MAX_WORD_IDX = (1 << (PC_BITS - 1)) - 1;

   // Step sizes
   localparam logic [PC_BITS-1:0]  PC_STEP    = 12'd2;
   localparam logic [CYC_BITS-1:0] CYC_MEM_OP = 16'd2;
   localparam logic [CYC_BITS-1:0] CYC_BR_OP  = 16'd1;

   // Function codes
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_LDA  = 4'd0,
      FUNC_STO  = 4'd1,
      FUNC_ADD  = 4'd2,
      FUNC_SUB  = 4'd3,
      FUNC_JMP  = 4'd4,
      FUNC_JGE  = 4'd5,
      FUNC_JNE  = 4'd6,
      FUNC_STP  = 4'd7,
      FUNC_MEMW = 4'd8
   } func_type;

endpackage

`default_nettype wire

FILE: src/accumulator_cpu_execute.sv
// Top level: accumulator machine execute block with its word memory.
// An accepted item has its operand read into the operand stage, then is
// executed into the result register once that register is free.
// Throughput: one item per cycle while rsp_tready keeps the result register
// free; the operand read of the next item overlaps execution of the current
// one through the memory's single read port. Reset: state registers clear at
// once; a clearing pass then zeroes every memory word, with req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_cpu_execute
   import acex_pkg::*;
#(
   parameter int MEM_WORDS = DEF_MEM_WORDS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // req item: func[3:0], addr[15:4], load_word[31:16]
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   // rsp item: acc_value[15:0], next_pc[27:16], halted[28], cycles[44:29], zero[47:45]
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(MEM_WORDS);

   logic                 clr_busy;
   logic [IDX_W-1:0]     clr_addr;
   logic [IDX_W-1:0]     ex_rd_addr, ex_wr_addr;
   logic                 ex_wr_en;
   logic [WORD_BITS-1:0] ex_wr_data, rd_data;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;

   acex_clear #(
      .MEM_WORDS(MEM_WORDS)
   ) u_clear (
      .clock    (clock),
      .reset    (reset),
      .clr_busy (clr_busy),
      .clr_addr (clr_addr)
   );

   acex_exec #(
      .MEM_WORDS(MEM_WORDS),
      .WORD_BITS(WORD_BITS)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .clr_busy    (clr_busy),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mem_rd_addr (ex_rd_addr),
      .mem_rd_data (rd_data),
      .mem_wr_en   (ex_wr_en),
      .mem_wr_addr (ex_wr_addr),
      .mem_wr_data (ex_wr_data)
   );

   // Give the write port to the clearing pass while it runs
   assign ram_we    = clr_busy || ex_wr_en;
   assign ram_waddr = clr_busy ? clr_addr : ex_wr_addr;
   assign ram_wdata = clr_busy ? '0 : ex_wr_data;

   acex_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MEM_WORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ex_rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

FILE: src/acex_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module acex_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, then read old contents on the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/acex_clear.sv
// Post-reset sweep that zeroes every word of the memory.
`timescale 1ns / 1ps
`default_nettype none

module acex_clear
   import acex_pkg::*;
#(
   parameter int MEM_WORDS = DEF_MEM_WORDS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   output logic                              clr_busy,
   output logic [$clog2(MEM_WORDS)-1:0]      clr_addr
);

   localparam int IDX_W = $clog2(MEM_WORDS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] addr_ff, addr_in;

   // Advance one word a cycle until the last one is written
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clr_busy = busy_ff;
   assign clr_addr = addr_ff;

endmodule

`default_nettype wire

FILE: src/acex_exec.sv
// Two-stage execute pipeline: operand read, then execute and result register.
`timescale 1ns / 1ps
`default_nettype none

module acex_exec
   import acex_pkg::*;
#(
   parameter int MEM_WORDS = DEF_MEM_WORDS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clr_busy,
   // req item: func[3:0], addr[15:4], load_word[31:16]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0]     req_tdata,
   // rsp item: acc_value[15:0], next_pc[27:16], halted[28], cycles[44:29], zero[47:45]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]          rsp_tdata,
   // memory ports
   output logic [$clog2(MEM_WORDS)-1:0]       mem_rd_addr,
   input  wire logic [WORD_BITS-1:0]          mem_rd_data,
   output logic                               mem_wr_en,
   output logic [$clog2(MEM_WORDS)-1:0]       mem_wr_addr,
   output logic [WORD_BITS-1:0]               mem_wr_data
);

   localparam int IDX_W = $clog2(MEM_WORDS);

   // Unpack request fields
   logic [FUNC_BITS-1:0] req_func;
   logic [PC_BITS-1:0]   req_addr;
   logic [LOAD_BITS-1:0] req_load;

   assign req_func = req_tdata[FUNC_BITS-1:0];
   assign req_addr = req_tdata[FUNC_BITS+PC_BITS-1:FUNC_BITS];
   assign req_load = req_tdata[FUNC_BITS+PC_BITS+LOAD_BITS-1:FUNC_BITS+PC_BITS];

   // Operand stage registers
   logic                 s1_valid_ff, s1_valid_in;
   func_type             s1_func_ff;
   logic [PC_BITS-1:0]   s1_addr_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [LOAD_BITS-1:0] s1_load_ff;

   // Machine state
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic [CYC_BITS-1:0]  cyc_ff, cyc_in;
   logic                 halt_ff, halt_in;

   // Result register
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_TDATA_BITS-1:0] out_data_ff;

   // Write-to-read forwarding
   logic                 fwd_ff, fwd_in;
   logic [WORD_BITS-1:0] fwd_data_ff;

   logic                 exec_fire, req_fire;
   logic [15:0]          idx_rem;
   logic [IDX_W-1:0]     req_idx;
   logic [WORD_BITS-1:0] operand;
   logic                 ex_we;
   logic [WORD_BITS-1:0] ex_wdata;
   logic [PC_BITS-1:0]   target;

   // Handshake and stage advance
   assign exec_fire  = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = (!s1_valid_ff || exec_fire) && !clr_busy;
   assign req_fire   = req_tvalid && req_tready;

   // Reduce the byte address to a word index modulo the memory depth
   always_comb begin
      idx_rem = 16'(req_addr[PC_BITS-1:1]);
      for (int k = 6; k >= 0; k--) begin
         if ((MEM_WORDS << k) <= MAX_WORD_IDX) begin
            if (idx_rem >= 16'(MEM_WORDS << k)) begin
               idx_rem = idx_rem - 16'(MEM_WORDS << k);
            end
         end
      end
      req_idx = IDX_W'(idx_rem);
   end

   // Read the new item's operand, or re-read the held one while stalled
   assign mem_rd_addr = req_fire ? req_idx : s1_idx_ff;

   // Take the operand from the forward path if the last write hit it
   assign operand = fwd_ff ? fwd_data_ff : mem_rd_data;
   assign target  = {s1_addr_ff[PC_BITS-1:1], 1'b0};

   // Execute the held instruction
   always_comb begin
      acc_in   = acc_ff;
      pc_in    = pc_ff;
      cyc_in   = cyc_ff;
      halt_in  = halt_ff;
      ex_we    = 1'b0;
      ex_wdata = acc_ff;
      if (s1_func_ff == FUNC_MEMW) begin
         ex_we    = 1'b1;
         ex_wdata = WORD_BITS'(s1_load_ff);
      end else if (!halt_ff) begin
         case (s1_func_ff)
            FUNC_LDA: begin
               pc_in  = pc_ff + PC_STEP;
               cyc_in = cyc_ff + CYC_MEM_OP;
               acc_in = operand;
            end
            FUNC_STO: begin
               pc_in  = pc_ff + PC_STEP;
               cyc_in = cyc_ff + CYC_MEM_OP;
               ex_we  = 1'b1;
            end
            FUNC_ADD: begin
               pc_in  = pc_ff + PC_STEP;
               cyc_in = cyc_ff + CYC_MEM_OP;
               acc_in = acc_ff + operand;
            end
            FUNC_SUB: begin
               pc_in  = pc_ff + PC_STEP;
               cyc_in = cyc_ff + CYC_MEM_OP;
               acc_in = acc_ff - operand;
            end
            FUNC_JMP: begin
               cyc_in = cyc_ff + CYC_BR_OP;
               pc_in  = target;
            end
            FUNC_JGE: begin
               cyc_in = cyc_ff + CYC_BR_OP;
               pc_in  = acc_ff[WORD_BITS-1] ? pc_ff + PC_STEP : target;
            end
            FUNC_JNE: begin
               cyc_in = cyc_ff + CYC_BR_OP;
               pc_in  = (acc_ff != '0) ? target : pc_ff + PC_STEP;
            end
            FUNC_STP: begin
               pc_in   = pc_ff + PC_STEP;
               cyc_in  = cyc_ff + CYC_BR_OP;
               halt_in = 1'b1;
            end
            default: begin
               // unused codes change nothing
               acc_in = acc_ff;
            end
         endcase
      end
   end

   assign mem_wr_en   = exec_fire && ex_we;
   assign mem_wr_addr = s1_idx_ff;
   assign mem_wr_data = ex_wdata;

   // Flag a read issued on the same word as this cycle's write
   assign fwd_in = mem_wr_en && (mem_wr_addr == mem_rd_addr);

   // Stage and result valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (exec_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (exec_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         cyc_ff       <= '0;
         halt_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         fwd_ff       <= fwd_in;
         if (exec_fire) begin
            acc_ff  <= acc_in;
            pc_ff   <= pc_in;
            cyc_ff  <= cyc_in;
            halt_ff <= halt_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= mem_wr_data;
      if (req_fire) begin
         s1_func_ff <= func_type'(req_func);
         s1_addr_ff <= req_addr;
         s1_idx_ff  <= req_idx;
         s1_load_ff <= req_load;
      end
      if (exec_fire) begin
         out_data_ff <= {3'b000, cyc_in, halt_in, pc_in, ACC_BITS'(acc_in)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire
